// ===== hw/rtl/mca_pkg.sv =====
// ----------------------------------------------------------------------------
// mca_pkg
// Shared constants and controller/datapath interface types for the mean
// complex amplitude block.
// ----------------------------------------------------------------------------
package mca_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int COUNT_WIDTH = 32;

  localparam int RAW_WIDTH   = 64;
  localparam int PART_WIDTH  = 32;
  localparam int SQ_WIDTH    = 64;
  localparam int SUM_WIDTH   = 64;
  localparam int CFG_WIDTH   = 32;
  localparam int IDX_WIDTH   = 2;
  localparam int STEP_WIDTH  = 5;

  // register indexes
  localparam logic [IDX_WIDTH-1:0] CFG_SAMPLE_FORMAT = 2'd0;
  localparam logic [IDX_WIDTH-1:0] CFG_BYTE_SWAP     = 2'd1;
  localparam logic [IDX_WIDTH-1:0] CFG_AMP_THRESHOLD = 2'd2;

  // sample format codes
  localparam logic FMT_FLOAT32 = 1'b0;
  localparam logic FMT_INT16   = 1'b1;

  // iterations of the root and divide loops
  localparam logic [STEP_WIDTH-1:0] ROOT_STEPS = 5'(SQ_WIDTH / 2 - 1);
  localparam logic [STEP_WIDTH-1:0] DIV_STEPS  = 5'(PART_WIDTH - 1);

  typedef struct packed {
    logic load;
    logic sq_re;
    logic sq_im;
    logic root_step;
    logic accumulate;
    logic div_init;
    logic div_step;
    logic publish;
  } mca_cmd_t;

  typedef struct packed {
    logic last;
    logic out_ready;
  } mca_sts_t;

endpackage

// ===== hw/rtl/mca_ctrl.sv =====
// ----------------------------------------------------------------------------
// mca_ctrl
// Sequencer: pixel load, two squares, bit-serial root, accumulate and, on
// the last pixel, bit-serial divide and result publish.
// ----------------------------------------------------------------------------
module mca_ctrl
  import mca_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     pixel_valid,
  output logic     pixel_stall,
  input  mca_sts_t sts,
  output mca_cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SQ_RE    = 3'd1;
  localparam logic [2:0] S_SQ_IM    = 3'd2;
  localparam logic [2:0] S_ROOT     = 3'd3;
  localparam logic [2:0] S_ACC      = 3'd4;
  localparam logic [2:0] S_DIV_INIT = 3'd5;
  localparam logic [2:0] S_DIV      = 3'd6;
  localparam logic [2:0] S_PUBLISH  = 3'd7;

  logic [2:0]            state, state_next;
  logic [STEP_WIDTH-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign pixel_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (pixel_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQ_RE;
        end
      end
      S_SQ_RE: begin
        cmd.sq_re  = 1'b1;
        state_next = S_SQ_IM;
      end
      S_SQ_IM: begin
        cmd.sq_im  = 1'b1;
        step_next  = ROOT_STEPS;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        step_next     = step - 5'd1;
        if (step == '0) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        state_next     = sts.last ? S_DIV_INIT : S_IDLE;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        step_next    = DIV_STEPS;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step - 5'd1;
        if (step == '0) begin
          state_next = S_PUBLISH;
        end
      end
      S_PUBLISH: begin
        if (sts.out_ready) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/mca_dp.sv =====
// ----------------------------------------------------------------------------
// mca_dp
// Datapath: configuration registers, part conversion, shared squarer,
// bit-serial square root, accumulators, bit-serial divider, result register.
// ----------------------------------------------------------------------------
module mca_dp
  import mca_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [IDX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  input  logic [RAW_WIDTH-1:0]   raw_pixel,
  input  logic                   last_pixel,
  input  mca_cmd_t               cmd,
  output mca_sts_t               sts,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [31:0]            mean_amplitude,
  output logic [COUNT_WIDTH-1:0] counted_pixels,
  output logic [COUNT_WIDTH-1:0] zero_pixels,
  output logic                   no_valid_pixels
);

  localparam logic [PART_WIDTH-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [PART_WIDTH-1:0] NEG_LIMIT = 32'h8000_0000;
  localparam logic [7:0]            EXP_UNITY = 8'(150 - FRAC_BITS);

  function automatic logic [PART_WIDTH-1:0] float_abs(input logic [31:0] b);
    logic [7:0]            ex;
    logic [23:0]           mant;
    logic [PART_WIDTH-1:0] lim;
    logic [PART_WIDTH-1:0] mag;
    logic [7:0]            sh;
    lim  = b[31] ? NEG_LIMIT : POS_LIMIT;
    ex   = b[30:23];
    mant = {1'b1, b[22:0]};
    sh   = '0;
    mag  = '0;
    if (ex == 8'hFF) begin
      mag = (b[22:0] != '0) ? '0 : lim;
    end else if (ex == 8'h00) begin
      mag = '0;
    end else if (ex >= EXP_UNITY) begin
      sh = ex - EXP_UNITY;
      if (sh >= 8'd8) begin
        mag = lim;
      end else begin
        mag = {8'b0, mant} << sh[2:0];
        if (mag > lim) begin
          mag = lim;
        end
      end
    end else begin
      sh = EXP_UNITY - ex;
      if (sh >= 8'd24) begin
        mag = '0;
      end else begin
        mag = {8'b0, mant >> sh[4:0]};
      end
    end
    return mag;
  endfunction

  function automatic logic [PART_WIDTH-1:0] int16_abs(input logic [15:0] b);
    logic [16:0] a;
    a = b[15] ? 17'(17'h10000 - {1'b0, b}) : {1'b0, b};
    return PART_WIDTH'(a) << FRAC_BITS;
  endfunction

  // configuration
  logic                 sample_format;
  logic                 byte_swap;
  logic [CFG_WIDTH-1:0] amp_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_FLOAT32;
      byte_swap     <= 1'b0;
      amp_threshold <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SAMPLE_FORMAT: sample_format <= cfg_data[0];
        CFG_BYTE_SWAP:     byte_swap     <= cfg_data[0];
        CFG_AMP_THRESHOLD: amp_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // part conversion
  logic [31:0]           f_re, f_im;
  logic [15:0]           i_re, i_im;
  logic [PART_WIDTH-1:0] re_conv, im_conv;

  always_comb begin
    f_re = raw_pixel[31:0];
    f_im = raw_pixel[63:32];
    i_re = raw_pixel[15:0];
    i_im = raw_pixel[31:16];
    if (byte_swap) begin
      f_re = {f_re[7:0], f_re[15:8], f_re[23:16], f_re[31:24]};
      f_im = {f_im[7:0], f_im[15:8], f_im[23:16], f_im[31:24]};
      i_re = {i_re[7:0], i_re[15:8]};
      i_im = {i_im[7:0], i_im[15:8]};
    end
    if (sample_format == FMT_INT16) begin
      re_conv = int16_abs(i_re);
      im_conv = int16_abs(i_im);
    end else begin
      re_conv = float_abs(f_re);
      im_conv = float_abs(f_im);
    end
  end

  // squares and root
  logic [PART_WIDTH-1:0] re_abs, im_abs, sq_op;
  logic                  last;
  logic [SQ_WIDTH-1:0]   sq_prod;
  logic [SQ_WIDTH-1:0]   rad, root, root_bit, trial;

  assign sq_op   = cmd.sq_im ? im_abs : re_abs;
  assign sq_prod = SQ_WIDTH'(sq_op) * SQ_WIDTH'(sq_op);
  assign trial   = root | root_bit;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      re_abs <= re_conv;
      im_abs <= im_conv;
      last   <= last_pixel;
    end
    if (cmd.sq_re) begin
      rad      <= sq_prod;
      root     <= '0;
      root_bit <= SQ_WIDTH'(1) << (SQ_WIDTH - 2);
    end else if (cmd.sq_im) begin
      rad <= rad + sq_prod;
    end else if (cmd.root_step) begin
      if (rad >= trial) begin
        rad  <= rad - trial;
        root <= (root >> 1) | root_bit;
      end else begin
        root <= root >> 1;
      end
      root_bit <= root_bit >> 2;
    end
  end

  // accumulators
  logic [SUM_WIDTH-1:0]   amplitude_sum;
  logic [COUNT_WIDTH-1:0] valid_count, low_count;
  logic [PART_WIDTH-1:0]  mag;

  assign mag = root[PART_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.publish) begin
      amplitude_sum <= '0;
      valid_count   <= '0;
      low_count     <= '0;
    end else if (cmd.accumulate) begin
      if (mag > amp_threshold) begin
        if (!(&valid_count)) begin
          amplitude_sum <= amplitude_sum + SUM_WIDTH'(mag);
          valid_count   <= valid_count + 1'b1;
        end
      end else if (!(&low_count)) begin
        low_count <= low_count + 1'b1;
      end
    end
  end

  // divider
  logic [PART_WIDTH-1:0] rem, quot;
  logic                  div_ovf;
  logic [PART_WIDTH:0]   rem_shift;
  logic [PART_WIDTH:0]   divisor;
  logic                  div_ge;

  assign divisor   = {{(PART_WIDTH + 1 - COUNT_WIDTH){1'b0}}, valid_count};
  assign rem_shift = {rem, quot[PART_WIDTH-1]};
  assign div_ge    = (rem_shift >= divisor);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= amplitude_sum[SUM_WIDTH-1:PART_WIDTH];
      quot    <= amplitude_sum[PART_WIDTH-1:0];
      div_ovf <= ({1'b0, amplitude_sum[SUM_WIDTH-1:PART_WIDTH]} >= divisor);
    end else if (cmd.div_step && !div_ovf) begin
      rem  <= div_ge ? PART_WIDTH'(rem_shift - divisor) : rem_shift[PART_WIDTH-1:0];
      quot <= {quot[PART_WIDTH-2:0], div_ge};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.publish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      no_valid_pixels <= (valid_count == '0);
      counted_pixels  <= valid_count;
      zero_pixels     <= low_count;
      if (valid_count == '0) begin
        mean_amplitude <= '0;
      end else if (div_ovf) begin
        mean_amplitude <= '1;
      end else begin
        mean_amplitude <= quot;
      end
    end
  end

  assign sts.last      = last;
  assign sts.out_ready = !result_valid || !result_stall;

endmodule

// ===== hw/rtl/mean_complex_amplitude.sv =====
// ----------------------------------------------------------------------------
// mean_complex_amplitude
// Mean magnitude of a stream of complex pixels, float32 or int16 parts.
//
// Pixel channel: raw_pixel and last_pixel with pixel_valid/pixel_stall; a
// word is taken when pixel_valid is high and pixel_stall is low. Each pixel
// holds the block after it is taken (two squares on a shared 32x32
// multiplier, a 32-step bit-serial square root, one accumulate), so the
// next pixel is taken only once the block is idle again.
// Result channel: one word per pixel marked last, with result_valid and
// result_stall. After the last pixel a 32-step bit-serial divider runs before
// the result is published into the output register.
// The result sits in an output register; new pixels are taken while it
// waits. Only a second last pixel holds if the earlier result is still
// stalled, and nothing is dropped.
// Configuration: cfg_write, cfg_index, cfg_data; write only while idle.
// Reset (rst, synchronous) clears the configuration to float32, no byte
// swap, threshold zero, and empties the sum and both counters.
// ----------------------------------------------------------------------------
module mean_complex_amplitude
  import mca_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [IDX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic [RAW_WIDTH-1:0]   raw_pixel,
  input  logic                   last_pixel,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [31:0]            mean_amplitude,
  output logic [COUNT_WIDTH-1:0] counted_pixels,
  output logic [COUNT_WIDTH-1:0] zero_pixels,
  output logic                   no_valid_pixels
);

  mca_cmd_t cmd;
  mca_sts_t sts;

  mca_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  mca_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .raw_pixel       (raw_pixel),
    .last_pixel      (last_pixel),
    .cmd             (cmd),
    .sts             (sts),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .mean_amplitude  (mean_amplitude),
    .counted_pixels  (counted_pixels),
    .zero_pixels     (zero_pixels),
    .no_valid_pixels (no_valid_pixels)
  );

endmodule
